### design/bllca_pkg.sv
package bllca_pkg;

  // Fixed field widths of node ids and depths
  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;

  // Depth saturates here
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

  // Request codes
  localparam logic REQ_ATTACH = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Parameter defaults
  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 10;

endpackage

### design/bllca_if.sv
interface bllca_in_if;
  import bllca_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, req_type, node_a, node_b, input ready);
  modport sink   (input valid, req_type, node_a, node_b, output ready);
endinterface

interface bllca_out_if;
  import bllca_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] ancestor_node;

  modport source (output valid, ancestor_node, input ready);
  modport sink   (input valid, ancestor_node, output ready);
endinterface

### design/bllca_ram.sv
module bllca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

### design/bllca_lift.sv
// Shared lift unit: picks the 2^lvl ancestor out of two rows and compares
// the depth held in a probed row against a reference depth.
module bllca_lift #(
  parameter int LEVELS = bllca_pkg::LEVELS_DEF,
  parameter int AW     = 10
) (
  input  logic [bllca_pkg::DEPTH_W+LEVELS*AW-1:0] row_a,
  input  logic [bllca_pkg::DEPTH_W+LEVELS*AW-1:0] row_b,
  input  logic [$clog2(LEVELS)-1:0]               lvl,
  input  logic [bllca_pkg::DEPTH_W+LEVELS*AW-1:0] probe_row,
  input  logic [bllca_pkg::DEPTH_W-1:0]           ref_depth,
  output logic [AW-1:0]                           anc_a,
  output logic [AW-1:0]                           anc_b,
  output logic                                    depth_ge
);
  import bllca_pkg::*;

  localparam int ROW_W = DEPTH_W + LEVELS * AW;

  assign anc_a    = row_a[int'(lvl) * AW +: AW];
  assign anc_b    = row_b[int'(lvl) * AW +: AW];
  assign depth_ge = (probe_row[ROW_W-1 -: DEPTH_W] >= ref_depth);

endmodule

### design/binary_lifting_lca_engine.sv
// Lowest common ancestor engine, binary lifting. Each tree node owns one row
// of a single two-read-port RAM: its depth and its 2^0 .. 2^(LEVELS-1)
// ancestors. Node 0 is the place above the root (depth 0, all ancestors 0).
// After reset the block clears the RAM one row per cycle, row 0 up to
// MAX_NODES-1, and holds in_ch.ready low until that is done. An attach
// transfer (req_type 0: node_a under parent node_b, 0 for the root) gives
// no result; attach parents before children. A query transfer (req_type 1)
// returns one ancestor_node transfer. Its work is a chain of dependent RAM
// reads: every lift step reads the row of the node the previous step chose,
// one row per cycle per port. One item is in work at a time; a result waits
// in the output register while the next item is taken. Ids at or above
// MAX_NODES read as node 0; attach of node 0 is dropped. Depth saturates at
// 1023. Querying a node never attached gives an undefined answer.
module binary_lifting_lca_engine #(
  parameter int MAX_NODES = bllca_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = bllca_pkg::LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  bllca_in_if.sink          in_ch,
  bllca_out_if.source       out_ch
);
  import bllca_pkg::*;

  localparam int AW    = $clog2(MAX_NODES);
  localparam int LW    = $clog2(LEVELS);
  localparam int ROW_W = DEPTH_W + LEVELS * AW;

  localparam logic [LW-1:0] LVL_TOP  = LW'(LEVELS - 1);
  localparam logic [AW-1:0] ADDR_TOP = AW'(MAX_NODES - 1);

  // Sequencer states
  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_ATT_STEP = 4'd2;
  localparam logic [3:0] ST_ATT_WR   = 4'd3;
  localparam logic [3:0] ST_Q_SWAP   = 4'd4;
  localparam logic [3:0] ST_Q_LIFT   = 4'd5;
  localparam logic [3:0] ST_Q_JUMP   = 4'd6;
  localparam logic [3:0] ST_Q_DONE   = 4'd7;

  // One RAM row per node
  typedef struct packed {
    logic [DEPTH_W-1:0]         depth;
    logic [LEVELS-1:0][AW-1:0]  anc;
  } row_t;

  // Out-of-range ids map to node 0
  function automatic logic [AW-1:0] node_idx(input logic [NODE_W-1:0] id);
    return (32'(id) < MAX_NODES) ? AW'(id) : '0;
  endfunction

  logic [3:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic [AW-1:0]      u_r, u_nxt;
  logic [AW-1:0]      v_r, v_nxt;
  logic [AW-1:0]      cand_a_r, cand_a_nxt;
  logic [AW-1:0]      cand_b_r, cand_b_nxt;
  row_t               urow_r, urow_nxt;
  row_t               vrow_r, vrow_nxt;
  logic [DEPTH_W-1:0] depv_r, depv_nxt;
  logic [AW-1:0]      child_r, child_nxt;
  row_t               arow_r, arow_nxt;
  logic [AW-1:0]      ans_r, ans_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]  out_node_r, out_node_nxt;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  row_t          ram_wdata;
  logic [AW-1:0] ra_addr, rb_addr;
  row_t          ra_row, rb_row;

  // Shared lift unit
  logic [LW-1:0]      sel_lvl;
  row_t               probe_row;
  logic [DEPTH_W-1:0] ref_depth;
  logic [AW-1:0]      anc_a, anc_b;
  logic               depth_ge;

  logic          in_fire;
  logic          out_free;
  logic [AW-1:0] a_idx, b_idx;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_fire       = in_ch.valid & in_ch.ready;
  assign a_idx         = node_idx(in_ch.node_a);
  assign b_idx         = node_idx(in_ch.node_b);
  assign out_free      = !out_valid_r || out_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.ancestor_node = out_node_r;

  bllca_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .ra_addr (ra_addr),
    .ra_data (ra_row),
    .rb_addr (rb_addr),
    .rb_data (rb_row)
  );

  bllca_lift #(
    .LEVELS (LEVELS),
    .AW     (AW)
  ) u_lift (
    .row_a     (urow_nxt),
    .row_b     (vrow_nxt),
    .lvl       (sel_lvl),
    .probe_row (probe_row),
    .ref_depth (ref_depth),
    .anc_a     (anc_a),
    .anc_b     (anc_b),
    .depth_ge  (depth_ge)
  );

  // Depth compare inputs: in the swap step it orders the two query nodes,
  // in the lift step it tests the candidate against the shallower node.
  always_comb begin
    probe_row = ra_row;
    ref_depth = (state_r == ST_Q_SWAP) ? rb_row.depth : depv_r;
  end

  // Current u/v and their rows, plus the level the lift unit selects for
  // the next read.
  always_comb begin
    u_nxt    = u_r;
    v_nxt    = v_r;
    urow_nxt = urow_r;
    vrow_nxt = vrow_r;
    sel_lvl  = lvl_r - 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_ch.req_type == REQ_QUERY) begin
          u_nxt = a_idx;
          v_nxt = b_idx;
        end
      end
      ST_ATT_STEP: begin
        // walk the just-read row: 2^i ancestor = (2^(i-1) anc)'s 2^(i-1) anc;
        // a walk that comes back to the child uses the row being built
        if (arow_r.anc[sel_lvl] == child_r) begin
          urow_nxt = arow_r;
        end else begin
          urow_nxt = ra_row;
        end
      end
      ST_Q_SWAP: begin
        // u is the deeper node
        if (depth_ge) begin
          urow_nxt = ra_row;
          vrow_nxt = rb_row;
        end else begin
          u_nxt    = v_r;
          v_nxt    = u_r;
          urow_nxt = rb_row;
          vrow_nxt = ra_row;
        end
        sel_lvl = LVL_TOP;
      end
      ST_Q_LIFT: begin
        if (depth_ge) begin
          u_nxt    = cand_a_r;
          urow_nxt = ra_row;
        end
        if (lvl_r == '0) begin
          sel_lvl = LVL_TOP;
        end
      end
      ST_Q_JUMP: begin
        if (cand_a_r != cand_b_r) begin
          u_nxt    = cand_a_r;
          v_nxt    = cand_b_r;
          urow_nxt = ra_row;
          vrow_nxt = rb_row;
        end
        if (lvl_r == '0) begin
          sel_lvl = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    lvl_nxt       = lvl_r;
    cand_a_nxt    = cand_a_r;
    cand_b_nxt    = cand_b_r;
    depv_nxt      = depv_r;
    child_nxt     = child_r;
    arow_nxt      = arow_r;
    ans_nxt       = ans_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_node_nxt  = out_node_r;
    ram_we        = 1'b0;
    ram_waddr     = child_r;
    ram_wdata     = arow_r;
    ra_addr       = cand_a_r;
    rb_addr       = cand_b_r;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_TOP) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.req_type == REQ_QUERY) begin
            ra_addr   = a_idx;
            rb_addr   = b_idx;
            state_nxt = ST_Q_SWAP;
          end else if (a_idx != '0) begin
            // node 0 and out-of-range children are dropped
            child_nxt       = a_idx;
            arow_nxt        = '0;
            arow_nxt.anc[0] = b_idx;
            ra_addr         = b_idx;
            lvl_nxt         = LW'(1);
            state_nxt       = ST_ATT_STEP;
          end
        end
      end

      ST_ATT_STEP: begin
        arow_nxt.anc[lvl_r] = anc_a;
        if (lvl_r == LW'(1)) begin
          // row just read is the parent's
          arow_nxt.depth = (ra_row.depth == DEPTH_MAX) ? DEPTH_MAX
                                                       : ra_row.depth + 1'b1;
        end
        if (lvl_r == LVL_TOP) begin
          state_nxt = ST_ATT_WR;
        end else begin
          ra_addr = anc_a;
          lvl_nxt = lvl_r + 1'b1;
        end
      end

      ST_ATT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = child_r;
        ram_wdata = arow_r;
        state_nxt = ST_IDLE;
      end

      ST_Q_SWAP: begin
        depv_nxt   = vrow_nxt.depth;
        cand_a_nxt = anc_a;
        ra_addr    = anc_a;
        lvl_nxt    = LVL_TOP;
        state_nxt  = ST_Q_LIFT;
      end

      ST_Q_LIFT: begin
        if (lvl_r != '0) begin
          cand_a_nxt = anc_a;
          ra_addr    = anc_a;
          lvl_nxt    = lvl_r - 1'b1;
        end else if (u_nxt == v_r) begin
          // v was an ancestor of u
          ans_nxt   = v_r;
          state_nxt = ST_Q_DONE;
        end else begin
          cand_a_nxt = anc_a;
          cand_b_nxt = anc_b;
          ra_addr    = anc_a;
          rb_addr    = anc_b;
          lvl_nxt    = LVL_TOP;
          state_nxt  = ST_Q_JUMP;
        end
      end

      ST_Q_JUMP: begin
        if (lvl_r != '0) begin
          cand_a_nxt = anc_a;
          cand_b_nxt = anc_b;
          ra_addr    = anc_a;
          rb_addr    = anc_b;
          lvl_nxt    = lvl_r - 1'b1;
        end else begin
          // u and v now sit just below the meeting point
          ans_nxt   = anc_a;
          state_nxt = ST_Q_DONE;
        end
      end

      ST_Q_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = NODE_W'(ans_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    cand_a_r   <= cand_a_nxt;
    cand_b_r   <= cand_b_nxt;
    urow_r     <= urow_nxt;
    vrow_r     <= vrow_nxt;
    depv_r     <= depv_nxt;
    child_r    <= child_nxt;
    arow_r     <= arow_nxt;
    ans_r      <= ans_nxt;
    out_node_r <= out_node_nxt;
  end

endmodule
